// ===== hw/rtl/ism_pkg.sv =====
// Shared types and constants for the integer stack machine.
// No dependencies; every other file of the block but ism_ram imports this package.
`default_nettype none

package ism_pkg;

	localparam int DATA_W            = 32;
	localparam int OP_W              = 3;
	localparam int STATUS_W          = 3;
	localparam int STACK_DEPTH_DEF   = 32;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_DROP = 3'd1,
		OP_ADD  = 3'd2,
		OP_SWAP = 3'd3,
		OP_ROLL = 3'd4,
		OP_LIST = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_UNDERFLOW = 3'd1,
		STAT_OVERFLOW  = 3'd2,
		STAT_DEPTH     = 3'd3,
		STAT_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMIT,
		S_ADD_TOP,
		S_ADD_SUM,
		S_ROLL_CNT,
		S_SINK_CAP,
		S_SINK_SHIFT,
		S_SINK_PLACE,
		S_LIST
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		status_t                  status;
	} res_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ism_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one stack command per word.
// Depends on ism_pkg for field widths.
`default_nettype none

interface ism_cmd_if;
	import ism_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] operand_value;

	modport source (output valid, output operation, output operand_value, input ready);
	modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ism_res_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on ism_pkg for field widths.
`default_nettype none

interface ism_res_if;
	import ism_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     last;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output result_value, output last, output status, input ready);
	modport sink   (input valid, input result_value, input last, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/integer_stack_machine.sv =====
// Integer stack machine: a bounded stack of signed 32-bit words in one RAM
// with a registered read, stepped by one command per input word. Each
// command walks its own run of sequencer states, and any stall on the result
// channel holds it; the single RAM read port moves or reads one entry per
// cycle while the result channel does not stall. Commands are taken one at
// a time, the next one is accepted while the final result word still sits
// in the output register. A refused command leaves the stack as it was and
// answers with an error status.
// Depends on ism_pkg, ism_cmd_if, ism_res_if, ism_ram, ism_ctrl, ism_out_stage.
`default_nettype none

module integer_stack_machine #(
	parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ism_cmd_if.sink   cmd,
	ism_res_if.source res
);
	import ism_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;
	logic              req_valid, req_ready;
	res_word_t         req;

	ism_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ism_ctrl #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	ism_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.res       (res)
	);
endmodule

`default_nettype wire

// ===== hw/rtl/ism_ram.sv =====
// Generic single-write, single-read RAM with a registered, enable-gated read.
// No package dependency.
`default_nettype none

module ism_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/ism_out_stage.sv =====
// Output register between the sequencer and the result channel.
// Depends on ism_pkg (res_word_t) and ism_res_if.
`default_nettype none

module ism_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire ism_pkg::res_word_t req,
	output logic                   req_ready,
	ism_res_if.source              res
);
	import ism_pkg::*;

	logic      valid_q;
	res_word_t word_q;

	assign req_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_ready) begin
			valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			word_q <= req;
		end
	end

	assign res.valid        = valid_q;
	assign res.result_value = word_q.value;
	assign res.last         = word_q.last;
	assign res.status       = word_q.status;
endmodule

`default_nettype wire

// ===== hw/rtl/ism_ctrl.sv =====
// Command sequencer: holds the entry count and walks the stack RAM
// (read, modify, write back). Depends on ism_pkg and ism_cmd_if.
`default_nettype none

module ism_ctrl #(
	parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ism_cmd_if.sink                             cmd,
	output logic                                ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0]      ram_waddr,
	output logic [ism_pkg::DATA_W-1:0]          ram_wdata,
	output logic                                ram_re,
	output logic [$clog2(STACK_DEPTH)-1:0]      ram_raddr,
	input  wire logic [ism_pkg::DATA_W-1:0]     ram_rdata,
	output logic                                req_valid,
	output ism_pkg::res_word_t                  req,
	input  wire logic                           req_ready
);
	import ism_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   dest_q, dest_d;
	logic [DATA_W-1:0] top_q, top_d;
	status_t         status_q, status_d;

	logic [CW-1:0]   count_m1, count_m2, roll_dest;
	logic [AW-1:0]   top_idx, sec_idx, ptr_m1;
	logic            full, ge2;
	op_t             op;

	assign count_m1  = count_q - CW'(1);
	assign count_m2  = count_q - CW'(2);
	assign top_idx   = count_m1[AW-1:0];
	assign sec_idx   = count_m2[AW-1:0];
	assign ptr_m1    = ptr_q - AW'(1);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign ge2       = (count_q >= CW'(2));
	assign roll_dest = count_m1 - ram_rdata[CW-1:0];
	assign op        = op_t'(cmd.operation);

	assign cmd.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		dest_q   <= dest_d;
		top_q    <= top_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		dest_d    = dest_q;
		top_d     = top_q;
		status_d  = status_q;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		req_valid = 1'b0;
		req       = '{value: '0, last: 1'b1, status: status_q};

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					unique case (op)
						OP_PUSH: begin
							state_d = S_EMIT;
							if (full) begin
								status_d = STAT_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								ram_wdata = cmd.operand_value;
								count_d   = count_q + CW'(1);
								status_d  = STAT_OK;
							end
						end
						OP_DROP: begin
							state_d = S_EMIT;
							if (count_q == '0) begin
								status_d = STAT_UNDERFLOW;
							end else begin
								count_d  = count_m1;
								status_d = STAT_OK;
							end
						end
						OP_ADD, OP_SWAP, OP_ROLL: begin
							if (!ge2) begin
								status_d = STAT_UNDERFLOW;
								state_d  = S_EMIT;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = top_idx;
								ptr_d     = top_idx;
								dest_d    = sec_idx;
								if (op == OP_ADD) begin
									state_d = S_ADD_TOP;
								end else if (op == OP_SWAP) begin
									state_d = S_SINK_CAP;
								end else begin
									state_d = S_ROLL_CNT;
								end
							end
						end
						OP_LIST: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
								state_d  = S_EMIT;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = top_idx;
								ptr_d     = top_idx;
								state_d   = S_LIST;
							end
						end
						default: begin
							// undefined opcode: drop it, no result
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_ADD_TOP: begin
				top_d     = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = sec_idx;
				state_d   = S_ADD_SUM;
			end

			S_ADD_SUM: begin
				ram_we    = 1'b1;
				ram_waddr = sec_idx;
				ram_wdata = ram_rdata + top_q;
				count_d   = count_m1;
				status_d  = STAT_OK;
				state_d   = S_EMIT;
			end

			S_ROLL_CNT: begin
				// rdata holds the roll count; a count of one or less only pops
				if (ram_rdata[DATA_W-1] || ram_rdata <= DATA_W'(1)) begin
					count_d  = count_m1;
					status_d = STAT_OK;
					state_d  = S_EMIT;
				end else if (ram_rdata > DATA_W'(count_m1)) begin
					status_d = STAT_DEPTH;
					state_d  = S_EMIT;
				end else begin
					count_d   = count_m1;
					ram_re    = 1'b1;
					ram_raddr = sec_idx;
					ptr_d     = sec_idx;
					dest_d    = roll_dest[AW-1:0];
					state_d   = S_SINK_CAP;
				end
			end

			S_SINK_CAP: begin
				top_d     = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = ptr_m1;
				state_d   = S_SINK_SHIFT;
			end

			S_SINK_SHIFT: begin
				// move one entry up per cycle while the next read is in flight
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				if (ptr_m1 == dest_q) begin
					state_d = S_SINK_PLACE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q - AW'(2);
					ptr_d     = ptr_m1;
				end
			end

			S_SINK_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = dest_q;
				ram_wdata = top_q;
				status_d  = STAT_OK;
				state_d   = S_EMIT;
			end

			S_LIST: begin
				// rdata holds until the next read, so a stalled word waits here
				req_valid = 1'b1;
				req       = '{value: ram_rdata, last: (ptr_q == '0), status: STAT_OK};
				if (req_ready) begin
					if (ptr_q == '0) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_m1;
						ptr_d     = ptr_m1;
					end
				end
			end

			S_EMIT: begin
				req_valid = 1'b1;
				if (req_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

`default_nettype wire
